@@ design/ultrasonic_echo_ranging_macros.svh @@
// ----------------------------------------------------------------------------
// Ultrasonic echo ranging assertion macros
// Clocked concurrent checks on clk_i, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_ECHO_RANGING_MACROS_SVH
`define ULTRASONIC_ECHO_RANGING_MACROS_SVH

`ifndef NO_ASSERTIONS
// check gated by the active-low reset
`define UER_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("ultrasonic echo ranging check failed");
// check that also holds while reset is asserted
`define UER_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("ultrasonic echo ranging check failed");
`else
`define UER_ASSERT(lbl, prop)
`define UER_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

@@ design/uer_pkg.sv @@
// ----------------------------------------------------------------------------
// Ultrasonic echo ranging package
// Transaction types, configuration record, phase and status codes.
// ----------------------------------------------------------------------------
package uer_pkg;

  localparam int unsigned TimerW = 24;
  localparam int unsigned WidthW = 16;
  localparam int unsigned DistW  = 26;
  localparam int unsigned FailW  = 4;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;

  typedef enum logic [1:0] {
    PH_TRIG = 2'd0,
    PH_WAIT = 2'd1,
    PH_MEAS = 2'd2,
    PH_IDLE = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_TIMEOUT = 2'd1,
    ST_RANGE   = 2'd2,
    ST_HELD    = 2'd3
  } status_e;

  localparam logic [CfgIdxW-1:0] REG_TRIGGER_LEN  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_ECHO_TIMEOUT = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_INTERVAL     = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_MIN_WIDTH    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_MAX_WIDTH    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_FAIL_LIMIT   = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_HALF_SPEED   = 3'd6;

  localparam logic [TimerW-1:0] TimerMax = {TimerW{1'b1}};
  localparam logic [WidthW-1:0] WidthMax = {WidthW{1'b1}};

  typedef struct packed {
    logic echo;
    logic us_tick;
  } in_t;

  typedef struct packed {
    logic             trigger;
    logic             done_res;
    status_e          status;
    logic [DistW-1:0] distance_um;
    phase_e           phase;
  } out_t;

  typedef struct packed {
    logic [7:0]       trigger_len_us;
    logic [19:0]      echo_timeout_us;
    logic [23:0]      interval_us;
    logic [15:0]      min_width_us;
    logic [15:0]      max_width_us;
    logic [FailW-1:0] fail_limit;
    logic [9:0]       half_speed;
  } cfg_t;

endpackage

@@ design/ultrasonic_echo_ranging.sv @@
// ----------------------------------------------------------------------------
// Ultrasonic echo ranging controller
// Trigger, echo wait, width measure and idle sequencing with range results.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_data_i): one transaction per
//   clock sample of the echo pin, with a flag for each elapsed microsecond.
//   Output channel (out_valid_o / out_ready_i / out_data_o): exactly one
//   result per input transaction, giving trigger drive, phase, the held
//   distance and, on the reporting transaction, done_res with a status.
//   Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i in the
//   same cycle; write only while no transaction is in flight.
//   Latency: a result is presented the cycle after its input is accepted.
//   Throughput: one transaction per cycle while the output is not stalled; the
//   whole sample update, including the 16 x 10 width-by-speed multiply, sits
//   between the sequencer state and the single output register.
//   Stall: while the output register is full and out_ready_i is low, input is
//   refused and the result holds; when the receiver takes it, a new input is
//   accepted in the same cycle.
//   Reset: rst_ni clears the sequencer to the trigger phase, the distance and
//   fail count to zero, empties the output register and restores defaults.
// ----------------------------------------------------------------------------
`include "ultrasonic_echo_ranging_macros.svh"

module ultrasonic_echo_ranging
  import uer_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_t                 in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_t                out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  cfg_t cfg;
  out_t res;
  out_t out_q;
  logic out_valid_q, out_valid_d;
  logic accept;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_d = accept || (out_valid_q && !out_ready_i);

  uer_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  uer_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .in_i     (in_data_i),
    .cfg_i    (cfg),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // status is only non-zero on a reporting transaction
  `UER_ASSERT(a_status_quiet, (out_valid_q && !out_q.done_res) |-> (out_q.status == ST_OK))
  // trigger drive follows the phase the sample was taken in
  `UER_ASSERT(a_trigger_phase, out_valid_q |-> (out_q.trigger == (out_q.phase == PH_TRIG)))
  // an empty output register never blocks the input side
  `UER_ASSERT_ALWAYS(a_ready_empty, !out_valid_q |-> in_ready_o)

endmodule

@@ design/uer_cfg.sv @@
// ----------------------------------------------------------------------------
// Ultrasonic echo ranging configuration registers
// Write-only register file, one register for each of indices 0 to 6, reset to defaults.
// ----------------------------------------------------------------------------
module uer_cfg
  import uer_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TRIGGER_LEN:  cfg_d.trigger_len_us  = cfg_wdata_i[7:0];
        REG_ECHO_TIMEOUT: cfg_d.echo_timeout_us = cfg_wdata_i[19:0];
        REG_INTERVAL:     cfg_d.interval_us     = cfg_wdata_i[23:0];
        REG_MIN_WIDTH:    cfg_d.min_width_us    = cfg_wdata_i[15:0];
        REG_MAX_WIDTH:    cfg_d.max_width_us    = cfg_wdata_i[15:0];
        REG_FAIL_LIMIT:   cfg_d.fail_limit      = cfg_wdata_i[FailW-1:0];
        REG_HALF_SPEED:   cfg_d.half_speed      = cfg_wdata_i[9:0];
        default: ; // unmapped index, ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trigger_len_us  <= 8'd10;
      cfg_q.echo_timeout_us <= 20'd100000;
      cfg_q.interval_us     <= 24'd1000000;
      cfg_q.min_width_us    <= 16'd100;
      cfg_q.max_width_us    <= 16'd20000;
      cfg_q.fail_limit      <= 4'd3;
      cfg_q.half_speed      <= 10'd170;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ design/uer_core.sv @@
// ----------------------------------------------------------------------------
// Ultrasonic echo ranging core
// Phase sequencer, echo edge tracking, width count and distance update.
// ----------------------------------------------------------------------------
`include "ultrasonic_echo_ranging_macros.svh"

module uer_core
  import uer_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic accept_i,
  input  in_t  in_i,
  input  cfg_t cfg_i,
  output out_t res_o
);

  phase_e            phase_q, phase_d;
  logic [TimerW-1:0] timer_q, timer_d;
  logic [WidthW-1:0] width_q, width_d;
  logic              rise_q, rise_d;
  logic              echo_last_q;
  logic [FailW-1:0]  fail_q, fail_d;
  logic [DistW-1:0]  dist_q, dist_d;

  logic [TimerW-1:0] t_inc;
  logic [FailW-1:0]  fail_inc;
  logic [DistW-1:0]  product;
  logic              width_ok;
  logic              falling;
  logic              done;
  status_e           status;

  assign t_inc    = (in_i.us_tick && (timer_q != TimerMax)) ? timer_q + 1'b1 : timer_q;
  assign fail_inc = fail_q + 1'b1;
  assign product  = DistW'(width_q) * DistW'(cfg_i.half_speed);
  assign width_ok = (width_q > cfg_i.min_width_us) && (width_q < cfg_i.max_width_us);

  // next state
  always_comb begin
    phase_d = phase_q;
    timer_d = t_inc;
    width_d = width_q;
    rise_d  = rise_q;
    fail_d  = fail_q;
    dist_d  = dist_q;
    falling = 1'b0;
    case (phase_q)
      PH_TRIG: begin
        if (t_inc >= TimerW'(cfg_i.trigger_len_us)) begin
          phase_d = PH_WAIT;
          timer_d = '0;
          rise_d  = 1'b0;
          width_d = '0;
        end
      end
      PH_WAIT: begin
        if (in_i.echo && !echo_last_q) begin
          rise_d  = 1'b1;
          width_d = '0;
        end
        if (rise_d && in_i.echo && in_i.us_tick && (width_d != WidthMax)) begin
          width_d = width_d + 1'b1;
        end
        falling = rise_d && !in_i.echo && echo_last_q;
        if (falling) begin
          phase_d = PH_MEAS;
          timer_d = '0;
        end else if (t_inc >= TimerW'(cfg_i.echo_timeout_us)) begin
          phase_d = PH_IDLE;
          timer_d = '0;
        end
      end
      PH_MEAS: begin
        if (width_ok) begin
          dist_d = product;
          fail_d = '0;
        end else if (fail_inc >= cfg_i.fail_limit) begin
          fail_d = '0;
        end else begin
          fail_d = fail_inc;
        end
        phase_d = PH_IDLE;
        timer_d = '0;
      end
      default: begin
        if (t_inc >= cfg_i.interval_us) begin
          phase_d = PH_TRIG;
          timer_d = '0;
        end
      end
    endcase
  end

  // outcome of this transaction
  always_comb begin
    done   = 1'b0;
    status = ST_OK;
    case (phase_q)
      PH_WAIT: begin
        if (!falling && (t_inc >= TimerW'(cfg_i.echo_timeout_us))) begin
          done   = 1'b1;
          status = ST_TIMEOUT;
        end
      end
      PH_MEAS: begin
        done = 1'b1;
        if (width_ok) begin
          status = ST_OK;
        end else if (fail_inc >= cfg_i.fail_limit) begin
          status = ST_RANGE;
        end else begin
          status = ST_HELD;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_TRIG;
      timer_q     <= '0;
      width_q     <= '0;
      rise_q      <= 1'b0;
      echo_last_q <= 1'b0;
      fail_q      <= '0;
      dist_q      <= '0;
    end else if (accept_i) begin
      phase_q     <= phase_d;
      timer_q     <= timer_d;
      width_q     <= width_d;
      rise_q      <= rise_d;
      echo_last_q <= in_i.echo;
      fail_q      <= fail_d;
      dist_q      <= dist_d;
    end
  end

  assign res_o.trigger     = (phase_q == PH_TRIG);
  assign res_o.done_res    = done;
  assign res_o.status      = status;
  assign res_o.distance_um = dist_d;
  assign res_o.phase       = phase_q;

  // a measure transaction always hands over to the idle interval
  `UER_ASSERT(a_meas_to_idle, (accept_i && phase_q == PH_MEAS) |=> (phase_q == PH_IDLE))
  // the fail count is cleared before it can pass the largest limit
  `UER_ASSERT(a_fail_bound, fail_q != {FailW{1'b1}})
  // the held distance moves only on a measure transaction
  `UER_ASSERT(a_dist_update, !$stable(dist_q) |-> $past(accept_i && phase_q == PH_MEAS))

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ultrasonic echo ranging testbench
// Drives echo samples through the valid/ready input channel, predicts every
// result with an in-bench model of the trigger/wait/measure/idle sequencer
// and compares each result field by field. Directed cases cover the echo edge
// corners, timeouts, the fail limit and the register extremes; randomised
// measurement cycles with random settings and noise follow.
// ----------------------------------------------------------------------------
module tb;
  import uer_pkg::*;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  in_t                 in_data_i;
  logic                out_valid_o;
  logic                out_ready_i;
  out_t                out_data_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  ultrasonic_echo_ranging dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // sequencer model state
  cfg_t              m_cfg;
  phase_e            m_phase;
  logic [TimerW-1:0] m_timer;
  logic [WidthW-1:0] m_width;
  logic              m_rise;
  logic              m_echo_last;
  logic [FailW-1:0]  m_fails;
  logic [DistW-1:0]  m_dist;

  out_t pending_results[$];
  int   err_cnt  = 0;
  int   n_sent   = 0;
  int   tx_idle  = 27;
  int   rx_idle  = 80;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  initial begin
    #10_000_000;
    $display("tb NOT OK");
    $finish;
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= rx_idle);
  end

  function automatic logic chance(int pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic void start_phase(phase_e p);
    m_phase = p;
    m_timer = '0;
  endfunction

  // advances the model by one echo sample and returns the result it causes
  function automatic out_t ranging_step(in_t s);
    out_t              r;
    phase_e            ph;
    logic [TimerW-1:0] t;
    logic              done;
    status_e           st;
    ph   = m_phase;
    done = 1'b0;
    st   = ST_OK;
    t    = m_timer;
    if (s.us_tick && t != TimerMax) t = t + 1'b1;
    m_timer = t;
    case (ph)
      PH_TRIG: begin
        if (t >= m_cfg.trigger_len_us) begin
          start_phase(PH_WAIT);
          m_rise  = 1'b0;
          m_width = '0;
        end
      end
      PH_WAIT: begin
        if (s.echo && !m_echo_last) begin
          m_rise  = 1'b1;
          m_width = '0;
        end
        if (m_rise && s.echo && s.us_tick && m_width != WidthMax) m_width = m_width + 1'b1;
        // falling edge takes priority over a coincident timeout
        if (m_rise && !s.echo && m_echo_last) begin
          start_phase(PH_MEAS);
        end else if (t >= m_cfg.echo_timeout_us) begin
          done = 1'b1;
          st   = ST_TIMEOUT;
          start_phase(PH_IDLE);
        end
      end
      PH_MEAS: begin
        done = 1'b1;
        if (m_width > m_cfg.min_width_us && m_width < m_cfg.max_width_us) begin
          m_dist  = DistW'(m_width) * DistW'(m_cfg.half_speed);
          m_fails = '0;
          st      = ST_OK;
        end else begin
          m_fails = m_fails + 1'b1;
          if (m_fails >= m_cfg.fail_limit) begin
            m_fails = '0;
            st      = ST_RANGE;
          end else begin
            st = ST_HELD;
          end
        end
        start_phase(PH_IDLE);
      end
      default: begin
        if (t >= m_cfg.interval_us) start_phase(PH_TRIG);
      end
    endcase
    m_echo_last   = s.echo;
    r.trigger     = (ph == PH_TRIG);
    r.done_res    = done;
    r.status      = st;
    r.distance_um = m_dist;
    r.phase       = ph;
    return r;
  endfunction

  always @(posedge clk_i) begin : result_check
    out_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          $error("result transaction with nothing pending");
          err_cnt++;
        end else begin
          want = pending_results.pop_front();
          if (out_data_o.trigger !== want.trigger) begin
            $error("trigger: expected %0d, got %0d", want.trigger, out_data_o.trigger);
            err_cnt++;
          end
          if (out_data_o.done_res !== want.done_res) begin
            $error("done_res: expected %0d, got %0d", want.done_res, out_data_o.done_res);
            err_cnt++;
          end
          if (out_data_o.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data_o.status);
            err_cnt++;
          end
          if (out_data_o.distance_um !== want.distance_um) begin
            $error("distance_um: expected %0d, got %0d", want.distance_um,
                   out_data_o.distance_um);
            err_cnt++;
          end
          if (out_data_o.phase !== want.phase) begin
            $error("phase: expected %0d, got %0d", want.phase, out_data_o.phase);
            err_cnt++;
          end
        end
      end
      if (in_valid_i && in_ready_o) pending_results.push_back(ranging_step(in_data_i));
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_sample(input logic e, input logic t);
    while (chance(tx_idle)) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= in_t'{echo: e, us_tick: t};
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    n_sent++;
  endtask

  task automatic drain();
    int waited;
    in_valid_i <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 5000) begin
      @(negedge clk_i);
      waited++;
    end
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      err_cnt++;
      pending_results.delete();
    end
    repeat (3) @(negedge clk_i);
  endtask

  task automatic reconfigure(input cfg_t c);
    logic [CfgIdxW-1:0] idx;
    logic [CfgDataW-1:0] val;
    drain();
    m_cfg = c;
    for (int i = 0; i < 7; i++) begin
      idx = i[CfgIdxW-1:0];
      case (idx)
        REG_TRIGGER_LEN:  val = CfgDataW'(c.trigger_len_us);
        REG_ECHO_TIMEOUT: val = CfgDataW'(c.echo_timeout_us);
        REG_INTERVAL:     val = CfgDataW'(c.interval_us);
        REG_MIN_WIDTH:    val = CfgDataW'(c.min_width_us);
        REG_MAX_WIDTH:    val = CfgDataW'(c.max_width_us);
        REG_FAIL_LIMIT:   val = CfgDataW'(c.fail_limit);
        default:          val = CfgDataW'(c.half_speed);
      endcase
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= idx;
      cfg_wdata_i <= val;
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic cfg_t small_cfg();
    cfg_t c;
    c.trigger_len_us  = 8'd1;
    c.echo_timeout_us = 20'd40;
    c.interval_us     = 24'd0;
    c.min_width_us    = 16'd0;
    c.max_width_us    = 16'hFFFF;
    c.fail_limit      = 4'd3;
    c.half_speed      = 10'd1023;
    return c;
  endfunction

  function automatic cfg_t random_cfg();
    cfg_t c;
    c.trigger_len_us  = 8'($urandom_range(1, 5));
    c.echo_timeout_us = chance(15) ? 20'($urandom_range(1, 15)) :
                                     20'($urandom_range(20, 100));
    c.interval_us     = 24'($urandom_range(0, 6));
    c.min_width_us    = 16'($urandom_range(0, 12));
    c.max_width_us    = c.min_width_us + 16'($urandom_range(0, 20));
    c.fail_limit      = chance(50) ? 4'($urandom_range(1, 3)) : 4'($urandom_range(0, 15));
    c.half_speed      = 10'($urandom_range(0, 1023));
    return c;
  endfunction

  task automatic goto_phase(input phase_e p);
    while (m_phase != p) send_sample(1'b0, 1'b1);
  endtask

  // from the wait phase: low gap, high for width ticks, fall, measure item
  task automatic echo_pulse(input int gap, input int width);
    repeat (gap) send_sample(1'b0, 1'b1);
    repeat (width) send_sample(1'b1, 1'b1);
    send_sample(1'b0, 1'b1);
    send_sample(1'b0, 1'b0);
  endtask

  task automatic measure_width(input int width);
    goto_phase(PH_WAIT);
    echo_pulse(1, width);
  endtask

  task automatic test_defaults();
    send_sample(1'b0, 1'b0);
    send_sample(1'b1, 1'b0);
    repeat (12) send_sample(1'b0, 1'b1);
    reconfigure(small_cfg());
  endtask

  task automatic test_good_echo();
    goto_phase(PH_WAIT);
    echo_pulse(1, 3);
    send_sample(1'b0, 1'b1);
    // unticked samples inside the pulse are not counted
    goto_phase(PH_WAIT);
    send_sample(1'b1, 1'b1);
    send_sample(1'b1, 1'b0);
    send_sample(1'b1, 1'b0);
    send_sample(1'b1, 1'b1);
    send_sample(1'b0, 1'b0);
    send_sample(1'b1, 1'b1);
  endtask

  task automatic test_stale_echo();
    // echo already high on entry to the wait phase is not a rising edge
    goto_phase(PH_TRIG);
    send_sample(1'b1, 1'b1);
    send_sample(1'b1, 1'b1);
    send_sample(1'b0, 1'b1);
    echo_pulse(0, 2);
  endtask

  task automatic test_fall_at_timeout();
    cfg_t c;
    c = small_cfg();
    c.echo_timeout_us = 20'd4;
    reconfigure(c);
    goto_phase(PH_WAIT);
    send_sample(1'b0, 1'b1);
    send_sample(1'b1, 1'b1);
    send_sample(1'b1, 1'b1);
    send_sample(1'b0, 1'b1);
    send_sample(1'b0, 1'b0);
  endtask

  task automatic test_timeout();
    goto_phase(PH_WAIT);
    repeat (4) send_sample(1'b0, 1'b1);
    // rising edge but no fall before the timeout
    goto_phase(PH_WAIT);
    repeat (5) send_sample(1'b1, 1'b1);
  endtask

  task automatic test_invalid_widths();
    cfg_t c;
    c = small_cfg();
    c.min_width_us = 16'd4;
    c.max_width_us = 16'd7;
    c.fail_limit   = 4'd2;
    reconfigure(c);
    measure_width(4);
    measure_width(7);
    measure_width(5);
    c.fail_limit = 4'd0;
    reconfigure(c);
    measure_width(4);
    c.fail_limit = 4'd1;
    reconfigure(c);
    measure_width(7);
    c.fail_limit = 4'd15;
    reconfigure(c);
    measure_width(4);
    measure_width(8);
    c.half_speed = 10'd0;
    reconfigure(c);
    measure_width(6);
    c.min_width_us = 16'hFFFF;
    c.max_width_us = 16'd0;
    reconfigure(c);
    measure_width(3);
  endtask

  task automatic test_extremes();
    cfg_t c;
    c = small_cfg();
    c.trigger_len_us  = 8'd255;
    c.echo_timeout_us = 20'hFFFFF;
    c.interval_us     = 24'hFFFFFF;
    c.fail_limit      = 4'd15;
    // leave the idle phase while the interval is still short
    goto_phase(PH_TRIG);
    reconfigure(c);
    goto_phase(PH_WAIT);
    echo_pulse(2, 9);
    repeat (20) send_sample(chance(50), chance(80));
    // drop the interval so the idle phase ends on the next sample
    reconfigure(small_cfg());
    send_sample(1'b0, 1'b0);
  endtask

  task automatic random_echo_wait();
    int gap;
    int wt;
    int cnt;
    logic tk;
    if (chance(85)) begin
      gap = $urandom_range(0, 3);
      wt  = $urandom_range(0, 30);
      cnt = 0;
      repeat (gap) if (m_phase == PH_WAIT) send_sample(1'b0, chance(70));
      while (m_phase == PH_WAIT && cnt < wt) begin
        tk = chance(80);
        send_sample(1'b1, tk);
        if (tk) cnt++;
      end
      if (m_phase == PH_WAIT) send_sample(1'b0, chance(70));
    end else begin
      repeat ($urandom_range(1, 8)) if (m_phase == PH_WAIT) send_sample(chance(50), chance(60));
    end
  endtask

  task automatic test_random(input int n_items);
    int first;
    int next_cfg;
    first    = n_sent;
    next_cfg = n_sent;
    while (n_sent - first < n_items) begin
      if (n_sent >= next_cfg) begin
        reconfigure(random_cfg());
        next_cfg = n_sent + 100;
      end
      case (m_phase)
        PH_TRIG: send_sample(chance(10), chance(75));
        PH_WAIT: random_echo_wait();
        PH_MEAS: send_sample(chance(50), chance(50));
        default: send_sample(chance(30), chance(75));
      endcase
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_ready_i = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_wdata_i = '0;
    m_cfg.trigger_len_us  = 8'd10;
    m_cfg.echo_timeout_us = 20'd100000;
    m_cfg.interval_us     = 24'd1000000;
    m_cfg.min_width_us    = 16'd100;
    m_cfg.max_width_us    = 16'd20000;
    m_cfg.fail_limit      = 4'd3;
    m_cfg.half_speed      = 10'd170;
    m_phase     = PH_TRIG;
    m_timer     = '0;
    m_width     = '0;
    m_rise      = 1'b0;
    m_echo_last = 1'b0;
    m_fails     = '0;
    m_dist      = '0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    tx_idle = 27;
    rx_idle = 80;
    test_defaults();
    test_good_echo();
    test_stale_echo();
    test_fall_at_timeout();
    test_timeout();
    test_invalid_widths();
    test_extremes();
    test_random(330);

    drain();
    tx_idle = 80;
    rx_idle = 27;
    test_random(330);

    drain();
    tx_idle = 0;
    rx_idle = 0;
    test_random(340);

    drain();
    if (err_cnt == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
